// ===== src/b64sc_pkg.sv =====
// shared types, constants and alphabet functions of the base64 stream codec
`timescale 1ns / 1ps

package b64sc_pkg;

   localparam int BufWidth     = 12;
   localparam int CntWidth     = 4;
   localparam int MaxItems     = 4;
   localparam int ItemIdxWidth = $clog2(MaxItems);
   localparam int ItemCntWidth = $clog2(MaxItems + 1);

   localparam logic [7:0] CharPad = 8'h3D;

   typedef enum logic {
      OP_DATA   = 1'b0,
      OP_FINISH = 1'b1
   } b64sc_op_type;

   typedef enum logic {
      MODE_ENCODE = 1'b0,
      MODE_DECODE = 1'b1
   } b64sc_mode_type;

   typedef struct packed {
      logic [BufWidth-1:0] buffer;
      logic [CntWidth-1:0] count;
      logic                pad_seen;
   } b64sc_state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last;
      logic       pad_error;
   } b64sc_item_type;

   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

   // bit 6 set when the character is not in the alphabet
   function automatic logic [6:0] dec_value(input logic [7:0] c);
      logic [6:0] v;
      v = 7'h40;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v = {1'b0, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = {1'b0, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
         v = 7'd62;
      end else if (c == 8'h2F) begin
         v = 7'd63;
      end
      return v;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

endpackage

// ===== src/b64sc_step.sv =====
// one codec step: next state and the result group for one input item
`timescale 1ns / 1ps

module b64sc_step import b64sc_pkg::*; (
   input  b64sc_mode_type        mode,
   input  b64sc_state_type       state_cur,
   input  b64sc_op_type          opcode,
   input  logic [7:0]            data_byte,
   output b64sc_state_type       state_nxt,
   output b64sc_item_type        items [MaxItems],
   output logic [ItemCntWidth-1:0] n_items
);

   logic [ItemCntWidth-1:0] k;
   logic [6:0]              dv;
   logic [BufWidth-1:0]     sh_enc;
   logic [BufWidth-1:0]     sh_dec;
   logic [BufWidth-1:0]     sh_a;
   logic [BufWidth-1:0]     sh_b;
   logic [CntWidth-1:0]     cnt_enc;
   logic [CntWidth-1:0]     cnt_dec;
   logic [CntWidth-1:0]     r1;
   logic [CntWidth-1:0]     r2;
   logic [15:0]             mask;
   logic                    err;

   always_comb begin
      state_nxt = state_cur;
      k         = '0;
      for (int i = 0; i < MaxItems; i++) begin
         items[i] = '0;
      end
      dv      = dec_value(data_byte);
      sh_enc  = {state_cur.buffer[BufWidth-9:0], data_byte};
      sh_dec  = {state_cur.buffer[BufWidth-7:0], dv[5:0]};
      cnt_enc = state_cur.count + CntWidth'(8);
      cnt_dec = state_cur.count + CntWidth'(6);
      r1      = '0;
      r2      = '0;
      sh_a    = '0;
      sh_b    = '0;
      mask    = 16'(16'd1 << state_cur.count) - 16'd1;
      err     = 1'b0;

      if (opcode == OP_DATA) begin
         if (mode == MODE_ENCODE) begin
            state_nxt.buffer = sh_enc;
            state_nxt.count  = cnt_enc;
            if (cnt_enc >= CntWidth'(6)) begin
               r1 = cnt_enc - CntWidth'(6);
               sh_a = sh_enc >> r1;
               items[k[ItemIdxWidth-1:0]] = '{enc_char(sh_a[5:0]), 1'b1, 1'b0, 1'b0};
               k = k + ItemCntWidth'(1);
               state_nxt.count = r1;
               if (r1 >= CntWidth'(6)) begin
                  r2 = r1 - CntWidth'(6);
                  sh_b = sh_enc >> r2;
                  items[k[ItemIdxWidth-1:0]] = '{enc_char(sh_b[5:0]), 1'b1, 1'b0, 1'b0};
                  k = k + ItemCntWidth'(1);
                  state_nxt.count = r2;
               end
            end
         end else if (!(state_cur.pad_seen || is_space(data_byte))) begin
            if (data_byte == CharPad) begin
               state_nxt.pad_seen = 1'b1;
            end else if (!dv[6]) begin
               state_nxt.buffer = sh_dec;
               state_nxt.count  = cnt_dec;
               if (cnt_dec >= CntWidth'(8)) begin
                  r1 = cnt_dec - CntWidth'(8);
                  sh_a = sh_dec >> r1;
                  items[k[ItemIdxWidth-1:0]] = '{sh_a[7:0], 1'b1, 1'b0, 1'b0};
                  k = k + ItemCntWidth'(1);
                  state_nxt.count = r1;
               end
            end
         end
      end else begin
         if (mode == MODE_ENCODE) begin
            if (state_cur.count != '0) begin
               if (state_cur.count < CntWidth'(6)) begin
                  sh_a = state_cur.buffer << (CntWidth'(6) - state_cur.count);
               end else begin
                  sh_a = state_cur.buffer >> (state_cur.count - CntWidth'(6));
               end
               items[k[ItemIdxWidth-1:0]] = '{enc_char(sh_a[5:0]), 1'b1, 1'b0, 1'b0};
               k = k + ItemCntWidth'(1);
               items[k[ItemIdxWidth-1:0]] = '{CharPad, 1'b1, 1'b0, 1'b0};
               k = k + ItemCntWidth'(1);
               if (state_cur.count <= CntWidth'(3)) begin
                  items[k[ItemIdxWidth-1:0]] = '{CharPad, 1'b1, 1'b0, 1'b0};
                  k = k + ItemCntWidth'(1);
               end
            end
         end else begin
            err = (state_cur.count != '0) &&
                  ((state_cur.buffer & mask[BufWidth-1:0]) != '0);
         end
         items[k[ItemIdxWidth-1:0]] = '{8'h00, 1'b0, 1'b0, err};
         k = k + ItemCntWidth'(1);
         state_nxt = '0;
      end

      for (int i = 0; i < MaxItems; i++) begin
         items[i].last = (ItemCntWidth'(i) + ItemCntWidth'(1) == k);
      end
      n_items = k;
   end

endmodule

// ===== src/base64_stream_codec_top.sv =====
// top level of the streaming base64 encoder and decoder
`timescale 1ns / 1ps

// Streaming base64 codec, standard alphabet with '=' padding.
// req_* carries one item per transfer: a data byte (raw byte or text character)
// or a finish that flushes, checks and clears the stream state.
// rsp_* returns the result items in order; rsp_last marks the final item of an
// input, and a finish always ends with a status item (rsp_byte_valid low) whose
// rsp_pad_error reports nonzero leftover bits in decode mode.
// csr_* writes the decode_mode bit (0 encode, 1 decode); csr_ready is always
// high and writes belong between streams, with the block drained.
// The first result of an item passes the input register, the group register
// and the result register before it shows on rsp. An input item produces zero
// to four results, which leave through the single result register one per cycle
// while rsp_stall is low; the next item enters the group once the last result
// of the group moves into the result register.
// Reset clears the stream state, the mode and all pipeline valids.
// A stalled result holds its payload; the group behind it waits, and req_stall
// rises once the input register cannot move on.
module base64_stream_codec_top import b64sc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last,
   output logic       rsp_pad_error,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_decode_mode
);

   logic                    in_valid_ff, in_valid_in;
   b64sc_op_type            in_op_ff, in_op_in;
   logic [7:0]              in_byte_ff, in_byte_in;
   b64sc_mode_type          mode_ff, mode_in;
   b64sc_state_type         state_ff, state_in;
   b64sc_item_type          grp_item_ff [MaxItems];
   b64sc_item_type          grp_item_in [MaxItems];
   logic [ItemCntWidth-1:0] grp_cnt_ff, grp_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   b64sc_item_type          rsp_item_ff, rsp_item_in;

   b64sc_state_type         step_state;
   b64sc_item_type          step_items [MaxItems];
   logic [ItemCntWidth-1:0] step_n;

   logic out_take, grp_pop, grp_free, proc, accept;

   b64sc_step u_step (
      .mode      (mode_ff),
      .state_cur (state_ff),
      .opcode    (in_op_ff),
      .data_byte (in_byte_ff),
      .state_nxt (step_state),
      .items     (step_items),
      .n_items   (step_n)
   );

   always_comb begin
      out_take  = !rsp_valid_ff || !rsp_stall;
      grp_pop   = (grp_cnt_ff != '0) && out_take;
      grp_free  = (grp_cnt_ff == '0) || ((grp_cnt_ff == ItemCntWidth'(1)) && grp_pop);
      proc      = in_valid_ff && grp_free;
      req_stall = in_valid_ff && !grp_free;
      accept    = req_valid && !req_stall;
      csr_ready = 1'b1;

      in_valid_in = in_valid_ff;
      in_op_in    = in_op_ff;
      in_byte_in  = in_byte_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_op_in    = b64sc_op_type'(req_opcode);
         in_byte_in  = req_data_byte;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end

      mode_in = mode_ff;
      if (csr_valid && csr_ready) begin
         mode_in = b64sc_mode_type'(csr_decode_mode);
      end

      state_in = state_ff;
      if (proc) begin
         state_in = step_state;
      end

      grp_item_in = grp_item_ff;
      grp_cnt_in  = grp_cnt_ff;
      if (proc) begin
         grp_item_in = step_items;
         grp_cnt_in  = step_n;
      end else if (grp_pop) begin
         for (int i = 0; i < MaxItems - 1; i++) begin
            grp_item_in[i] = grp_item_ff[i+1];
         end
         grp_cnt_in = grp_cnt_ff - ItemCntWidth'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (out_take) begin
         rsp_valid_in = (grp_cnt_ff != '0);
         rsp_item_in  = grp_item_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mode_ff      <= MODE_ENCODE;
         state_ff     <= '0;
         grp_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mode_ff      <= mode_in;
         state_ff     <= state_in;
         grp_cnt_ff   <= grp_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_op_ff    <= in_op_in;
      in_byte_ff  <= in_byte_in;
      grp_item_ff <= grp_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_item_ff.out_byte;
   assign rsp_byte_valid = rsp_item_ff.byte_valid;
   assign rsp_last       = rsp_item_ff.last;
   assign rsp_pad_error  = rsp_item_ff.pad_error;

endmodule

// ===== src/b64sc_checker.sv =====
// port-level checks of the base64 stream codec and their binding
`timescale 1ns / 1ps

module b64sc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_opcode,
   input logic [7:0] req_data_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_last,
   input logic       rsp_pad_error,
   input logic       csr_valid,
   input logic       csr_ready,
   input logic       csr_decode_mode
);

   // pipeline empties on reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall pending after reset");

   // status item closes the finish and carries no byte
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last && rsp_out_byte == 8'h00)
      else $error("malformed finish status item");

   a_err_on_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> !rsp_pad_error)
      else $error("pad error on a data item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_byte_valid) && $stable(rsp_last) && $stable(rsp_pad_error))
      else $error("stalled result changed");

endmodule

bind base64_stream_codec_top b64sc_checker u_b64sc_checker (.*);
